/* sv/sfor_pkg.sv */
// shared types and constants for the stereo fade-out ramp
// no dependencies

package sfor_pkg;

    localparam int GAIN_BITS      = 7;
    localparam int STEP_BITS      = 16;
    localparam int MASK_BITS      = 2;
    localparam int CFG_INDEX_BITS = 1;
    localparam int GAIN_DIVISOR   = 100;

    localparam logic [GAIN_BITS-1:0] GAIN_START = 7'd99;
    localparam logic [MASK_BITS-1:0] MASK_RESET = 2'd3;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd1;

    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;

    localparam t_cfg_index CFG_CHANNEL_MASK = 1'b0;
    localparam t_cfg_index CFG_STEP_LENGTH  = 1'b1;

    // load enables of the scaling stages behind the input register
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

/* sv/sfor_ramp.sv */
// gain ramp state: percent gain and frames left in the current step
// depends on sfor_pkg

module sfor_ramp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_restart,
    input  logic [sfor_pkg::STEP_BITS-1:0] i_step_length,
    output logic [sfor_pkg::GAIN_BITS-1:0] o_gain
);
    import sfor_pkg::*;

    logic [GAIN_BITS-1:0] r_gain, n_gain;
    logic [STEP_BITS-1:0] r_frames, n_frames;
    logic [GAIN_BITS-1:0] w_gain_eff;
    logic [STEP_BITS-1:0] w_frames_eff, w_frames_dec, w_reload;

    // zero step length behaves as one
    assign w_reload     = (i_step_length == '0) ? STEP_BITS'(1) : i_step_length;
    assign w_gain_eff   = i_restart ? GAIN_START : r_gain;
    assign w_frames_eff = i_restart ? w_reload : r_frames;
    assign w_frames_dec = w_frames_eff - STEP_BITS'(1);
    assign o_gain       = w_gain_eff;

    always_comb begin
        n_gain   = r_gain;
        n_frames = r_frames;
        if (i_accept) begin
            if (w_frames_dec == '0) begin
                n_frames = w_reload;
                n_gain   = (w_gain_eff != '0) ? w_gain_eff - GAIN_BITS'(1) : w_gain_eff;
            end else begin
                n_frames = w_frames_dec;
                n_gain   = w_gain_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_START;
            r_frames <= STEP_RESET;
        end else begin
            r_gain   <= n_gain;
            r_frames <= n_frames;
        end
    end

endmodule

/* sv/sfor_lane.sv */
// one channel of the scaler: |sample|*gain, divide by 100 via reciprocal, restore sign
// depends on sfor_pkg

module sfor_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  sfor_pkg::t_pipe_en            i_en,
    input  logic                          i_fade,
    input  logic [sfor_pkg::GAIN_BITS-1:0] i_gain,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    import sfor_pkg::*;

    localparam int MW = SAMPLE_BITS + GAIN_BITS;
    localparam int RW = MW - 6;
    localparam int PW = MW + RW;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << MW) / GAIN_DIVISOR);

    logic [SAMPLE_BITS-1:0] w_abs;
    logic [MW-1:0]          w_prod;
    logic [PW-1:0]          w_recip;
    logic [MW-1:0]          w_rem;
    logic [SAMPLE_BITS-1:0] w_q, w_res;

    logic [MW-1:0]          r_prod2, r_prod3;
    logic                   r_neg2, r_neg3, r_fade2, r_fade3;
    logic [SAMPLE_BITS-1:0] r_raw2, r_raw3, r_q3, r_out;

    // magnitude times gain
    assign w_abs  = i_sample[SAMPLE_BITS-1] ? -SAMPLE_BITS'(i_sample) : SAMPLE_BITS'(i_sample);
    assign w_prod = MW'(w_abs) * MW'(i_gain);

    // quotient estimate, at most one short of the true value
    assign w_recip = PW'(r_prod2) * PW'(RECIP);

    // one correction step, then sign back on
    assign w_rem = r_prod3 - MW'(r_q3) * MW'(GAIN_DIVISOR);
    assign w_q   = (w_rem >= MW'(GAIN_DIVISOR)) ? r_q3 + SAMPLE_BITS'(1) : r_q3;
    assign w_res = r_neg3 ? -w_q : w_q;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod2 <= w_prod;
            r_neg2  <= i_sample[SAMPLE_BITS-1];
            r_fade2 <= i_fade;
            r_raw2  <= SAMPLE_BITS'(i_sample);
        end
        if (i_en.s3) begin
            r_prod3 <= r_prod2;
            r_q3    <= SAMPLE_BITS'(w_recip >> MW);
            r_neg3  <= r_neg2;
            r_fade3 <= r_fade2;
            r_raw3  <= r_raw2;
        end
        if (i_en.s4) begin
            r_out <= r_fade3 ? w_res : r_raw3;
        end
    end

    assign o_sample = r_out;

endmodule

/* sv/stereo_fade_out_ramp.sv */
// stereo linear fade-out: top level with config registers, input register and stage control
// depends on sfor_pkg, sfor_ramp, sfor_lane
//
// usage
//   slave stream carries one stereo frame per transfer; tuser is the restart
//   flag, which reloads gain to 99 and the step counter before that frame
//   master stream returns one result per frame: both samples and the gain used
//   config channel writes channel_mask (index 0) and step_length (index 1);
//   it is always ready, writes are meant to land while the stream is idle
//   four register stages: input register, gain multiply, reciprocal multiply,
//   correction and output register
//   throughput is one frame per cycle while the receiver keeps tready high;
//   each stage has its own valid and loads whenever it is empty or the
//   stage after it moves on
//   when the receiver stalls, bubbles in the pipe still fill, so up to four
//   frames are taken before tready drops
//   the gain/counter state advances at the input transfer, so it never waits
//   on the output side
//   reset (synchronous, active low) empties the pipe, sets gain 99, counter 1,
//   channel_mask 3 and step_length 1

module stereo_fade_out_ramp #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: left_in, right_in (from bit 0), zero padded to bytes
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: restart
    input  logic                            i_s_axis_tuser,
    // master stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: left_out, right_out, gain_used (from bit 0), zero padded to bytes
    output logic [((2*SAMPLE_BITS+sfor_pkg::GAIN_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  sfor_pkg::t_cfg_index            i_cfg_index,
    input  logic [sfor_pkg::STEP_BITS-1:0]  i_cfg_data
);
    import sfor_pkg::*;

    localparam int OUT_BITS = 2 * SAMPLE_BITS + GAIN_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // config registers
    logic [MASK_BITS-1:0] r_channel_mask;
    logic [STEP_BITS-1:0] r_step_length;

    // stage valids; stage 4 is the output register
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic w_accept;
    t_pipe_en w_en;

    // input register payload
    logic signed [SAMPLE_BITS-1:0] r_left1, r_right1;
    logic [MASK_BITS-1:0]          r_fade1;
    logic [GAIN_BITS-1:0]          r_gain1, r_gain2, r_gain3, r_gain4;

    logic [GAIN_BITS-1:0]          w_gain;
    logic signed [SAMPLE_BITS-1:0] w_left_out, w_right_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_mask <= MASK_RESET;
            r_step_length  <= STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_MASK: r_channel_mask <= i_cfg_data[MASK_BITS-1:0];
                CFG_STEP_LENGTH:  r_step_length  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ready ripples back from the output; a stage loads when empty or draining
    assign w_rdy4   = !r_v4 || i_m_axis_tready;
    assign w_rdy3   = !r_v3 || w_rdy4;
    assign w_rdy2   = !r_v2 || w_rdy3;
    assign w_rdy1   = !r_v1 || w_rdy2;
    assign w_accept = i_s_axis_tvalid && w_rdy1;
    assign w_en     = '{s2: w_rdy2, s3: w_rdy3, s4: w_rdy4};

    assign o_s_axis_tready = w_rdy1;
    assign o_m_axis_tvalid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_s_axis_tvalid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // gain for the incoming frame, restart already applied
    sfor_ramp u_ramp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_restart     (i_s_axis_tuser),
        .i_step_length (r_step_length),
        .o_gain        (w_gain)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_left1  <= i_s_axis_tdata[SAMPLE_BITS-1:0];
            r_right1 <= i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            r_fade1  <= r_channel_mask;
            r_gain1  <= w_gain;
        end
        if (w_rdy2) r_gain2 <= r_gain1;
        if (w_rdy3) r_gain3 <= r_gain2;
        if (w_rdy4) r_gain4 <= r_gain3;
    end

    sfor_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_fade   (r_fade1[0]),
        .i_gain   (r_gain1),
        .i_sample (r_left1),
        .o_sample (w_left_out)
    );

    sfor_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_fade   (r_fade1[1]),
        .i_gain   (r_gain1),
        .i_sample (r_right1),
        .o_sample (w_right_out)
    );

    assign o_m_axis_tdata = OUT_W'({r_gain4, w_right_out, w_left_out});

endmodule

/* bench/fade_ramp_checker.sv */
// result checker for the stereo fade-out ramp: tracks the gain and step counter,
// predicts every output frame and compares it field by field with the master stream
// depends on sfor_pkg

module fade_ramp_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream as seen by the block
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  i_s_tdata,
    input  logic                                i_s_tuser,
    // master stream
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [((2*SAMPLE_BITS+sfor_pkg::GAIN_BITS+7)/8)*8-1:0] i_m_tdata,
    // config channel
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  sfor_pkg::t_cfg_index                i_cfg_index,
    input  logic [sfor_pkg::STEP_BITS-1:0]      i_cfg_data,
    // status for the bench top
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_results,
    output int                                  o_floor_frames
);

    import sfor_pkg::*;

    localparam int SB        = SAMPLE_BITS;
    localparam int PRINT_CAP = 40;

    // packed so that left sits in the lowest bits, as on the bus
    typedef struct packed {
        logic [GAIN_BITS-1:0] gain;
        logic [SB-1:0]        right;
        logic [SB-1:0]        left;
    } t_fade_frame;

    t_fade_frame expected_frames[$];

    logic [MASK_BITS-1:0] fade_mask;
    logic [STEP_BITS-1:0] step_len;
    logic [GAIN_BITS-1:0] gain_pct;
    logic [STEP_BITS-1:0] frames_left;

    task automatic report_mismatch(input string what);
        if (o_errors < PRINT_CAP) begin
            $display("%0t mismatch: %s", $time, what);
        end
        o_errors++;
    endtask

    function automatic logic [STEP_BITS-1:0] reload_count();
        return (step_len == '0) ? STEP_BITS'(1) : step_len;
    endfunction

    function automatic logic [SB-1:0] fade_sample(input logic [SB-1:0] raw, input logic fade);
        longint product;
        product = $signed(raw);
        if (fade) begin
            product = (product * longint'(gain_pct)) / GAIN_DIVISOR;
        end
        return product[SB-1:0];
    endfunction

    // gain/counter update happens at the input transfer
    task automatic step_ramp(input logic restart, input logic [SB-1:0] left_in,
                             input logic [SB-1:0] right_in, output t_fade_frame res);
        if (restart) begin
            gain_pct    = GAIN_START;
            frames_left = reload_count();
        end
        res.left  = fade_sample(left_in, fade_mask[0]);
        res.right = fade_sample(right_in, fade_mask[1]);
        res.gain  = gain_pct;
        frames_left = frames_left - STEP_BITS'(1);
        if (frames_left == '0) begin
            frames_left = reload_count();
            if (gain_pct != '0) begin
                gain_pct = gain_pct - GAIN_BITS'(1);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_fade_frame want;
        t_fade_frame got;
        t_fade_frame next_frame;
        if (!i_rst_n) begin
            fade_mask   = MASK_RESET;
            step_len    = STEP_RESET;
            gain_pct    = GAIN_START;
            frames_left = STEP_RESET;
            expected_frames.delete();
            o_errors       = 0;
            o_pending      = 0;
            o_results      = 0;
            o_floor_frames = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CHANNEL_MASK: fade_mask = i_cfg_data[MASK_BITS-1:0];
                    CFG_STEP_LENGTH:  step_len  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[2*SB+GAIN_BITS-1:0];
                o_results++;
                if (expected_frames.size() == 0) begin
                    report_mismatch($sformatf("result %h with no frame outstanding", got));
                end else begin
                    want = expected_frames.pop_front();
                    if (got.left !== want.left) begin
                        report_mismatch($sformatf("left_out %h, expected %h",
                                                  got.left, want.left));
                    end
                    if (got.right !== want.right) begin
                        report_mismatch($sformatf("right_out %h, expected %h",
                                                  got.right, want.right));
                    end
                    if (got.gain !== want.gain) begin
                        report_mismatch($sformatf("gain_used %0d, expected %0d",
                                                  got.gain, want.gain));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                step_ramp(i_s_tuser, i_s_tdata[SB-1:0], i_s_tdata[2*SB-1:SB], next_frame);
                if (next_frame.gain == '0) begin
                    o_floor_frames++;
                end
                expected_frames.push_back(next_frame);
            end
            o_pending = expected_frames.size();
        end
    end

endmodule

/* bench/testbench.sv */
// bench top for the stereo fade-out ramp: clock, reset, stimulus and verdict
// depends on sfor_pkg, stereo_fade_out_ramp and fade_ramp_checker

module testbench;

    import sfor_pkg::*;

    localparam int SB              = 16;
    localparam int IN_W            = ((2*SB+7)/8)*8;
    localparam int OUT_W           = ((2*SB+GAIN_BITS+7)/8)*8;
    // watchdog for the whole run, ample even with both sides idling
    localparam int CYCLE_LIMIT     = 400000;
    // pipe is four deep, give it a few cycles more to show any stray result
    localparam int DRAIN_CYCLES    = 16;
    // long receiver hold-off so the pipe fills and tready drops
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_PHASES   = 11;

    logic              clk = 1'b0;
    logic              rst_n;

    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    t_cfg_index        cfg_index;
    logic [STEP_BITS-1:0] cfg_data;

    int fade_errors;
    int fade_pending;
    int fade_results;
    int floor_frames;

    // stimulus bookkeeping for the summary
    int cycle_count   = 0;
    int input_stalls  = 0;
    int frames_sent   = 0;
    int restarts_sent = 0;
    int cfg_writes    = 0;

    // idling controls, changed between phases
    bit tx_idle;
    bit rx_idle;
    bit hold_request;

    stereo_fade_out_ramp #(
        .SAMPLE_BITS (SB)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    fade_ramp_checker #(
        .SAMPLE_BITS (SB)
    ) fade_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_errors       (fade_errors),
        .o_pending      (fade_pending),
        .o_results      (fade_results),
        .o_floor_frames (floor_frames)
    );

    always #4 clk = ~clk;

    // watchdog and back-pressure count
    always @(posedge clk) begin
        cycle_count++;
        if (rst_n && s_tvalid && !s_tready) begin
            input_stalls++;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, fade_pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: random stall before each transfer while rx_idle is set, plus one long hold-off on request
    initial begin : receiver
        int gap;
        m_tready = 1'b0;
        @(negedge clk);
        while (!rst_n) begin
            @(negedge clk);
        end
        forever begin
            if (hold_request) begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            // wait for the transfer itself
            @(posedge clk);
            while (!m_tvalid) begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    // offer one frame, called and returning at a falling edge
    task automatic send_frame(input logic restart, input logic [SB-1:0] left_in,
                              input logic [SB-1:0] right_in);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = restart;
        s_tdata  = {right_in, left_in};
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        @(negedge clk);
        frames_sent++;
        if (restart) begin
            restarts_sent++;
        end
    endtask

    // register write, only once every expected result is back so the pipe is empty
    task automatic write_reg(input t_cfg_index idx, input logic [STEP_BITS-1:0] value);
        s_tvalid = 1'b0;
        while (fade_pending != 0) begin
            @(negedge clk);
        end
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    // mix of full-scale corners, values near zero and full random words
    function automatic logic [SB-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hffff;
            4:       return 16'($urandom_range(0, 200) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int phase;
        int n;
        int len;
        int restart_rate;
        logic [MASK_BITS-1:0] mask_sel;
        logic [STEP_BITS-1:0] step_sel;
        logic [STEP_BITS-1:0] mask_word;
        logic restart;

        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_CHANNEL_MASK;
        cfg_data     = '0;
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_request = 1'b0;
        rst_n        = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed part, no idling on either side
        // reset settings: both channels faded, gain drops every frame
        send_frame(1'b0, 16'sd32767, -16'sd32768);
        send_frame(1'b0, -16'sd32768, 16'sd32767);
        // small values truncate toward zero
        send_frame(1'b0, -16'sd1, 16'sd1);
        send_frame(1'b0, 16'sd0, 16'sd0);
        send_frame(1'b0, -16'sd100, 16'sd100);
        // restart reloads the gain before this frame
        send_frame(1'b1, 16'sd32767, -16'sd32768);
        send_frame(1'b0, 16'sd12345, -16'sd12345);

        // empty channel mask and zero step length
        write_reg(CFG_CHANNEL_MASK, 16'h0000);
        write_reg(CFG_STEP_LENGTH, 16'h0000);
        send_frame(1'b0, -16'sd32768, 16'sd32767);
        send_frame(1'b1, 16'sd1, -16'sd1);
        send_frame(1'b0, 16'sd32767, -16'sd32768);

        // left only; new step length waits for the current step to finish
        write_reg(CFG_CHANNEL_MASK, 16'h0001);
        write_reg(CFG_STEP_LENGTH, 16'd3);
        repeat (4) send_frame(1'b0, 16'sd20000, -16'sd20000);

        // right only, longest step
        write_reg(CFG_CHANNEL_MASK, 16'h0002);
        write_reg(CFG_STEP_LENGTH, 16'hffff);
        send_frame(1'b1, -16'sd32768, -16'sd32768);
        send_frame(1'b0, 16'sd32767, 16'sd32767);
        send_frame(1'b0, -16'sd1, -16'sd1);

        // random phases, each with its own settings and idling
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                // fast ramp restarted only at its first frame, gain reaches the floor and stays there
                0: begin
                    mask_sel = 2'd3; step_sel = 16'd1; len = 130; restart_rate = 0;
                    tx_idle = 1'b1; rx_idle = 1'b1;
                end
                // zero step with empty mask, floor again
                1: begin
                    mask_sel = 2'd0; step_sel = 16'd0; len = 110; restart_rate = 0;
                    tx_idle = 1'b0; rx_idle = 1'b1;
                end
                2: begin
                    mask_sel = 2'd1; step_sel = 16'hffff; len = 60; restart_rate = 16;
                    tx_idle = 1'b1; rx_idle = 1'b0;
                end
                3: begin
                    mask_sel = 2'd2; step_sel = 16'd2; len = 90; restart_rate = 40;
                    tx_idle = 1'b1; rx_idle = 1'b1;
                end
                // back-pressure: sender keeps offering while the receiver holds off
                4: begin
                    mask_sel = 2'd3; step_sel = 16'($urandom_range(1, 5)); len = 80;
                    restart_rate = 30; tx_idle = 1'b0; rx_idle = 1'b0;
                end
                default: begin
                    mask_sel = 2'($urandom_range(0, 3));
                    case ($urandom_range(0, 6))
                        0:       step_sel = 16'd0;
                        1:       step_sel = 16'd1;
                        2:       step_sel = 16'd2;
                        3:       step_sel = 16'($urandom_range(3, 9));
                        4:       step_sel = 16'($urandom_range(10, 300));
                        5:       step_sel = 16'hffff;
                        default: step_sel = 16'($urandom);
                    endcase
                    len          = $urandom_range(65, 90);
                    restart_rate = $urandom_range(8, 64);
                    tx_idle      = ($urandom_range(0, 3) != 0);
                    rx_idle      = ($urandom_range(0, 3) != 0);
                end
            endcase

            // only the low bits of the mask word are meaningful, the rest is noise
            mask_word = 16'($urandom);
            mask_word[MASK_BITS-1:0] = mask_sel;
            write_reg(CFG_CHANNEL_MASK, mask_word);
            write_reg(CFG_STEP_LENGTH, step_sel);

            if (phase == 4) begin
                hold_request = 1'b1;
            end

            for (n = 0; n < len; n++) begin
                if (n == 0) begin
                    restart = (restart_rate == 0) ? 1'b1 : 1'($urandom_range(0, 1));
                end else begin
                    restart = (restart_rate != 0) && ($urandom_range(0, restart_rate - 1) == 0);
                end
                send_frame(restart, draw_sample(), draw_sample());
            end
        end

        // drain: every result back, then a few cycles for anything stray
        s_tvalid = 1'b0;
        while (fade_pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d frames (%0d with restart) over %0d register writes",
                 frames_sent, restarts_sent, cfg_writes);
        $display("%0d results checked, %0d at zero gain, %0d cycles of input back-pressure",
                 fade_results, floor_frames, input_stalls);
        if (fade_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
